// File: rtl/sfcd_pkg.sv
`default_nettype none

package sfcd_pkg;

   // Frame layout
   localparam int unsigned BYTE_W    = 8;
   localparam int unsigned POS_W     = 3;
   localparam int unsigned WORD_W    = 20;
   localparam int unsigned PAYLOAD_W = 2 * WORD_W;
   localparam int unsigned TEMP_W    = 15;
   localparam int unsigned HUM_W     = 14;

   localparam logic [POS_W-1:0] POS_FIRST = 3'd0;
   localparam logic [POS_W-1:0] POS_LAST  = 3'd6;

   // CRC-8, MSB first, no reflection, no final XOR
   localparam logic [BYTE_W-1:0] CRC_INIT = 8'hFF;
   localparam logic [BYTE_W-1:0] CRC_POLY = 8'h31;

   // Scaling to hundredths
   localparam logic [HUM_W-1:0]  HUM_SCALE   = 14'd10000;
   localparam logic [TEMP_W-1:0] TEMP_SCALE  = 15'd20000;
   localparam logic [TEMP_W-1:0] TEMP_OFFSET = 15'd5000;

   // Advance the CRC by one byte
   function automatic logic [BYTE_W-1:0] crc_byte(input logic [BYTE_W-1:0] crc,
                                                  input logic [BYTE_W-1:0] data);
      logic [BYTE_W-1:0] c;
      c = crc ^ data;
      for (int k = 0; k < BYTE_W; k++) begin
         if (c[BYTE_W-1]) begin
            c = {c[BYTE_W-2:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[BYTE_W-2:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

`default_nettype wire

// File: rtl/sfcd_req_if.sv
`default_nettype none

interface sfcd_req_if;
   import sfcd_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] rx_byte;
   logic              frame_start;

   modport source (output valid, output rx_byte, output frame_start, input ready);
   modport sink   (input valid, input rx_byte, input frame_start, output ready);
endinterface

`default_nettype wire

// File: rtl/sfcd_rsp_if.sv
`default_nettype none

interface sfcd_rsp_if;
   import sfcd_pkg::*;

   logic                     valid;
   logic                     ready;
   logic                     status;
   logic signed [TEMP_W-1:0] temperature_c100;
   logic        [HUM_W-1:0]  humidity_c100;

   modport source (output valid, output status, output temperature_c100,
                   output humidity_c100, input ready);
   modport sink   (input valid, input status, input temperature_c100,
                   input humidity_c100, output ready);
endinterface

`default_nettype wire

// File: rtl/sensor_frame_crc_decode.sv
`default_nettype none

// Channel   Dir  Fields                                        Moves
// req_chan  in   rx_byte[7:0], frame_start                     one frame byte
// rsp_chan  out  status, temperature_c100[14:0] (signed),      one decoded frame
//                humidity_c100[13:0]
//
// A request is taken every cycle while req_chan.ready is high; the frame state updates in the accept cycle.
// The seventh byte enters a check stage, and the result register takes it from
// there when the check stage advances.
// The scaling multipliers sit between the check stage and the result register.
// Synchronous reset sets position to byte 0 and CRC to its initial value, and clears both valid flags.
// A stalled result holds the check stage; requests stall only when both are full.

module sensor_frame_crc_decode (
   input  wire logic  clock,
   input  wire logic  reset,
   sfcd_req_if.sink   req_chan,
   sfcd_rsp_if.source rsp_chan
);
   import sfcd_pkg::*;

   logic [POS_W-1:0]     pos_ff, pos_in;
   logic [BYTE_W-1:0]    crc_ff, crc_in;
   logic [PAYLOAD_W-1:0] payload_ff, payload_in;

   logic                 p1_valid_ff, p1_valid_in;
   logic                 p1_status_ff;
   logic [WORD_W-1:0]    p1_rh_ff, p1_t_ff;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     rsp_status_ff;
   logic signed [TEMP_W-1:0] rsp_temp_ff;
   logic        [HUM_W-1:0]  rsp_hum_ff;

   logic                 req_accept;
   logic                 p1_advance;
   logic [POS_W-1:0]     cur_pos;
   logic                 is_last;
   logic [BYTE_W-1:0]    crc_seed;

   logic [WORD_W+HUM_W-1:0]  hum_prod;
   logic [WORD_W+TEMP_W-1:0] temp_prod;
   logic [TEMP_W-1:0]        temp_scaled;

   // Handshake: the check stage frees up when the result register can take it
   assign p1_advance       = p1_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready   = !p1_valid_ff || p1_advance;
   assign req_accept       = req_chan.valid && req_chan.ready;

   // Resolve the byte position; frame start and the unused code map to byte 0
   always_comb begin
      if (req_chan.frame_start || pos_ff > POS_LAST) begin
         cur_pos = POS_FIRST;
      end else begin
         cur_pos = pos_ff;
      end
      is_last  = (cur_pos == POS_LAST);
      crc_seed = (cur_pos == POS_FIRST) ? CRC_INIT : crc_ff;
   end

   // Next frame state
   always_comb begin
      pos_in      = pos_ff;
      crc_in      = crc_ff;
      payload_in  = payload_ff;
      p1_valid_in = p1_advance ? 1'b0 : p1_valid_ff;
      if (req_accept) begin
         if (is_last) begin
            pos_in      = POS_FIRST;
            p1_valid_in = 1'b1;
         end else begin
            pos_in = cur_pos + 3'd1;
            crc_in = crc_byte(crc_seed, req_chan.rx_byte);
            if (cur_pos != POS_FIRST) begin
               payload_in = {payload_ff[PAYLOAD_W-BYTE_W-1:0], req_chan.rx_byte};
            end
         end
      end
   end

   // Scale the raw words
   assign hum_prod    = (WORD_W+HUM_W)'(p1_rh_ff) * (WORD_W+HUM_W)'(HUM_SCALE);
   assign temp_prod   = (WORD_W+TEMP_W)'(p1_t_ff) * (WORD_W+TEMP_W)'(TEMP_SCALE);
   assign temp_scaled = temp_prod[WORD_W+TEMP_W-1:WORD_W];

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (p1_advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= POS_FIRST;
         crc_ff       <= CRC_INIT;
         p1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         crc_ff       <= crc_in;
         p1_valid_ff  <= p1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload shift register and check stage
   always_ff @(posedge clock) begin
      payload_ff <= payload_in;
      if (req_accept && is_last) begin
         p1_status_ff <= (crc_ff != req_chan.rx_byte);
         p1_rh_ff     <= payload_ff[PAYLOAD_W-1:WORD_W];
         p1_t_ff      <= payload_ff[WORD_W-1:0];
      end
   end

   // Result register; zero the readings on a checksum mismatch
   always_ff @(posedge clock) begin
      if (p1_advance) begin
         rsp_status_ff <= p1_status_ff;
         if (p1_status_ff) begin
            rsp_temp_ff <= '0;
            rsp_hum_ff  <= '0;
         end else begin
            rsp_temp_ff <= $signed(temp_scaled - TEMP_OFFSET);
            rsp_hum_ff  <= hum_prod[WORD_W+HUM_W-1:WORD_W];
         end
      end
   end

   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.status           = rsp_status_ff;
   assign rsp_chan.temperature_c100 = rsp_temp_ff;
   assign rsp_chan.humidity_c100    = rsp_hum_ff;

`ifndef ASSERT_OFF
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= POS_LAST)
      else $error("byte position out of range");

   a_last_loads_check: assert property (@(posedge clock) disable iff (reset)
      req_accept && is_last |=> p1_valid_ff && pos_ff == POS_FIRST)
      else $error("last byte did not load the check stage");

   a_advance_shows: assert property (@(posedge clock) disable iff (reset)
      p1_advance |=> rsp_valid_ff)
      else $error("check stage advanced without a result");

   a_mismatch_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff |-> rsp_temp_ff == '0 && rsp_hum_ff == '0)
      else $error("mismatch result carries readings");

   a_hum_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_hum_ff < HUM_SCALE)
      else $error("humidity out of range");
`endif

endmodule

`default_nettype wire

// File: bench/tb.sv
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import sfcd_pkg::*;

   localparam int unsigned QUIET_LIMIT     = 5000;
   localparam int unsigned HOLD_OFF_CYCLES = 300;
   localparam int unsigned DRAIN_CYCLES    = 10;
   localparam int unsigned PHASE_BYTES     = 470;
   localparam int unsigned PRESSURE_FRAMES = 20;
   localparam int unsigned RESET_CYCLES    = 8;

   localparam logic STATUS_OK      = 1'b0;
   localparam logic STATUS_CRC_ERR = 1'b1;

   typedef struct packed {
      logic                     status;
      logic signed [TEMP_W-1:0] temperature_c100;
      logic        [HUM_W-1:0]  humidity_c100;
   } reading_type;

   // How the byte of a script row is sent: as written, or replaced by the CRC or by the CRC with one bit flipped
   typedef enum logic [1:0] {BYTE_AS_IS, CRC_GOOD, CRC_BAD} last_byte_type;

   typedef struct packed {
      logic [BYTE_W-1:0] rx_byte;
      logic              frame_start;
      last_byte_type     fill;
      logic              typed;
      reading_type       want;
   } script_row_type;

   localparam reading_type READ_NONE    = '0;
   localparam reading_type READ_FLOOR   = '{STATUS_OK, -15'sd5000, 14'd0};
   localparam reading_type READ_CEIL    = '{STATUS_OK, 15'sd14999, 14'd9999};
   localparam reading_type READ_CRC_ERR = '{STATUS_CRC_ERR, 15'sd0, 14'd0};

   localparam int SCRIPT_LEN = 23;

   // Directed frames: all-zero payload, all-ones payload entered by wrap,
   // an aborted frame, then a restart by frame start with a bad checksum
   localparam script_row_type FRAME_SCRIPT [SCRIPT_LEN] = '{
      '{8'h1C, 1'b1, BYTE_AS_IS, 1'b0, READ_NONE},
      '{8'h00, 1'b0, BYTE_AS_IS, 1'b0, READ_NONE},
      '{8'h00, 1'b0, BYTE_AS_IS, 1'b0, READ_NONE},
      '{8'h00, 1'b0, BYTE_AS_IS, 1'b0, READ_NONE},
      '{8'h00, 1'b0, BYTE_AS_IS, 1'b0, READ_NONE},
      '{8'h00, 1'b0, BYTE_AS_IS, 1'b0, READ_NONE},
      '{8'h00, 1'b0, CRC_GOOD,   1'b1, READ_FLOOR},
      '{8'hFF, 1'b0, BYTE_AS_IS, 1'b0, READ_NONE},
      '{8'hFF, 1'b0, BYTE_AS_IS, 1'b0, READ_NONE},
      '{8'hFF, 1'b0, BYTE_AS_IS, 1'b0, READ_NONE},
      '{8'hFF, 1'b0, BYTE_AS_IS, 1'b0, READ_NONE},
      '{8'hFF, 1'b0, BYTE_AS_IS, 1'b0, READ_NONE},
      '{8'hFF, 1'b0, BYTE_AS_IS, 1'b0, READ_NONE},
      '{8'h00, 1'b0, CRC_GOOD,   1'b1, READ_CEIL},
      '{8'h18, 1'b1, BYTE_AS_IS, 1'b0, READ_NONE},
      '{8'hA5, 1'b0, BYTE_AS_IS, 1'b0, READ_NONE},
      '{8'h1C, 1'b1, BYTE_AS_IS, 1'b0, READ_NONE},
      '{8'h12, 1'b0, BYTE_AS_IS, 1'b0, READ_NONE},
      '{8'h34, 1'b0, BYTE_AS_IS, 1'b0, READ_NONE},
      '{8'h56, 1'b0, BYTE_AS_IS, 1'b0, READ_NONE},
      '{8'h78, 1'b0, BYTE_AS_IS, 1'b0, READ_NONE},
      '{8'h9A, 1'b0, BYTE_AS_IS, 1'b0, READ_NONE},
      '{8'h00, 1'b0, CRC_BAD,    1'b1, READ_CRC_ERR}
   };

   localparam int IDLE_PLAN  [4] = '{0, 72, 0, 11};
   localparam int STALL_PLAN [4] = '{0, 0, 72, 11};

   logic clock;
   logic reset;

   sfcd_req_if req_chan ();
   sfcd_rsp_if rsp_chan ();

   sensor_frame_crc_decode DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // Frame decoder state as seen by the bench
   logic [POS_W-1:0]     frame_pos     = POS_FIRST;
   logic [BYTE_W-1:0]    frame_crc     = CRC_INIT;
   logic [PAYLOAD_W-1:0] frame_payload = '0;

   reading_type pending_readings [$];
   int       error_count    = 0;
   int       bytes_sent     = 0;
   int       send_idle_pct  = 0;
   int       recv_stall_pct = 0;
   bit       hold_off_start = 1'b0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // CRC-8, one data bit per step, MSB first
   function automatic logic [BYTE_W-1:0] crc8_update(input logic [BYTE_W-1:0] crc,
                                                     input logic [BYTE_W-1:0] data);
      logic [BYTE_W-1:0] acc;
      logic              fb;
      acc = crc;
      for (int i = BYTE_W - 1; i >= 0; i--) begin
         fb  = acc[BYTE_W-1] ^ data[i];
         acc = {acc[BYTE_W-2:0], 1'b0} ^ (fb ? CRC_POLY : '0);
      end
      return acc;
   endfunction

   // Advance the frame state by one byte; return 1 when a reading comes out
   function automatic bit decode_byte(input logic [BYTE_W-1:0] b, input logic st,
                                      output reading_type r);
      logic [POS_W-1:0] pos;
      logic [63:0]      hum_wide;
      logic [63:0]      temp_wide;
      int               temp_int;
      pos = st ? POS_FIRST : frame_pos;
      if (pos > POS_LAST) begin
         pos = POS_FIRST;
      end
      r = '0;
      if (pos != POS_LAST) begin
         frame_crc = crc8_update((pos == POS_FIRST) ? CRC_INIT : frame_crc, b);
         if (pos != POS_FIRST) begin
            frame_payload = {frame_payload[PAYLOAD_W-BYTE_W-1:0], b};
         end
         frame_pos = pos + 1'b1;
         return 1'b0;
      end
      frame_pos = POS_FIRST;
      if (frame_crc != b) begin
         r.status = STATUS_CRC_ERR;
         return 1'b1;
      end
      hum_wide  = 64'(frame_payload[PAYLOAD_W-1:WORD_W]) * 64'(HUM_SCALE);
      temp_wide = 64'(frame_payload[WORD_W-1:0]) * 64'(TEMP_SCALE);
      temp_int  = int'(temp_wide >> WORD_W) - int'(TEMP_OFFSET);
      r.status           = STATUS_OK;
      r.humidity_c100    = hum_wide[WORD_W +: HUM_W];
      r.temperature_c100 = temp_int[TEMP_W-1:0];
      return 1'b1;
   endfunction

   // Pick the checksum byte from the running CRC, flip one bit of it, or pass the byte as given
   function automatic logic [BYTE_W-1:0] last_byte(input last_byte_type fill,
                                                   input logic [BYTE_W-1:0] b);
      case (fill)
         CRC_GOOD: begin
            return frame_crc;
         end
         CRC_BAD: begin
            return frame_crc ^ (8'h01 << $urandom_range(BYTE_W - 1));
         end
         default: begin
            return b;
         end
      endcase
   endfunction

   // Offer one request, wait for it to be taken, and record what it should yield
   task automatic push_byte(input logic [BYTE_W-1:0] b, input logic st,
                            input logic typed, input reading_type want);
      reading_type got;
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.rx_byte     <= b;
      req_chan.frame_start <= st;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      bytes_sent++;
      if (decode_byte(b, st, got)) begin
         pending_readings.push_back(typed ? want : got);
      end
   endtask

   // One random burst: mostly whole frames, some aborted frames, some noise
   task automatic send_frame();
      int                kind;
      int                n;
      int                extreme;
      int                pick;
      logic              st;
      logic [BYTE_W-1:0] b;
      last_byte_type     fill;
      kind = $urandom_range(99);
      if (kind < 80) begin
         st      = (frame_pos != POS_FIRST) || ($urandom_range(3) != 0);
         extreme = $urandom_range(19);
         push_byte(BYTE_W'($urandom_range(255)), st, 1'b0, READ_NONE);
         for (int i = 1; i < 6; i++) begin
            pick = $urandom_range(15);
            if (extreme == 0 || (extreme > 1 && pick == 0)) begin
               b = 8'h00;
            end else if (extreme == 1 || pick == 1) begin
               b = 8'hFF;
            end else begin
               b = BYTE_W'($urandom_range(255));
            end
            push_byte(b, 1'b0, 1'b0, READ_NONE);
         end
         if ($urandom_range(99) < 85) begin
            fill = CRC_GOOD;
         end else begin
            fill = CRC_BAD;
         end
         push_byte(last_byte(fill, 8'h00), 1'b0, 1'b0, READ_NONE);
      end else if (kind < 92) begin
         n = $urandom_range(6, 1);
         for (int i = 0; i < n; i++) begin
            push_byte(BYTE_W'($urandom_range(255)), i == 0, 1'b0, READ_NONE);
         end
      end else begin
         n = $urandom_range(8, 1);
         for (int i = 0; i < n; i++) begin
            push_byte(BYTE_W'($urandom_range(255)), $urandom_range(3) == 0, 1'b0,
                      READ_NONE);
         end
      end
   endtask

   // Drive requests: reset, directed script, pressure, then random phases
   initial begin
      reset                <= 1'b1;
      req_chan.valid       <= 1'b0;
      req_chan.rx_byte     <= '0;
      req_chan.frame_start <= 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      foreach (FRAME_SCRIPT[i]) begin
         push_byte(last_byte(FRAME_SCRIPT[i].fill, FRAME_SCRIPT[i].rx_byte),
                   FRAME_SCRIPT[i].frame_start, FRAME_SCRIPT[i].typed,
                   FRAME_SCRIPT[i].want);
      end

      for (int phase = 0; phase < 4; phase++) begin
         send_idle_pct  = IDLE_PLAN[phase];
         recv_stall_pct = STALL_PLAN[phase];
         bytes_sent     = 0;
         // Keep offering while the result side holds off, so the input backs up
         if (phase == 0) begin
            hold_off_start = 1'b1;
            for (int f = 0; f < PRESSURE_FRAMES; f++) begin
               send_frame();
            end
         end
         while (bytes_sent < PHASE_BYTES) begin
            send_frame();
         end
      end
      req_chan.valid <= 1'b0;

      while (pending_readings.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // Drive the result side ready: random stalls, plus one long hold-off
   initial begin
      int hold_left;
      hold_left = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_start) begin
            hold_off_start = 1'b0;
            hold_left      = HOLD_OFF_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // Compare each reading with the oldest pending one
   always @(posedge clock) begin
      reading_type want;
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         if (pending_readings.size() == 0) begin
            $error("reading with none pending: status %0d temperature_c100 %0d humidity_c100 %0d",
                   rsp_chan.status, rsp_chan.temperature_c100, rsp_chan.humidity_c100);
            error_count++;
         end else begin
            want = pending_readings.pop_front();
            if (rsp_chan.status !== want.status) begin
               $error("status: expected %0d, actual %0d", want.status, rsp_chan.status);
               error_count++;
            end
            if (rsp_chan.temperature_c100 !== want.temperature_c100) begin
               $error("temperature_c100: expected %0d, actual %0d",
                      want.temperature_c100, rsp_chan.temperature_c100);
               error_count++;
            end
            if (rsp_chan.humidity_c100 !== want.humidity_c100) begin
               $error("humidity_c100: expected %0d, actual %0d",
                      want.humidity_c100, rsp_chan.humidity_c100);
               error_count++;
            end
         end
      end
   end

   // End the run if neither side moves a request for too long
   always @(posedge clock) begin
      int quiet;
      if ((req_chan.valid === 1'b1 && req_chan.ready === 1'b1) ||
          (rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1)) begin
         quiet = 0;
      end else begin
         quiet++;
         if (quiet >= QUIET_LIMIT) begin
            $display("FAILURE");
            $finish;
         end
      end
   end

endmodule
